// ===== hdl/utf8s_pkg.sv =====
// Shared types and constants for the UTF-8 sanitizer.
// No dependencies; imported by utf8_sanitizer.
`timescale 1ns / 1ps
`default_nettype none

package utf8s_pkg;

	typedef logic [7:0] byte_t;

	// Most bytes one input transfer can release
	localparam int unsigned MaxResults = 4;
	localparam int unsigned CntW       = $clog2(MaxResults + 1);

	localparam byte_t REPL_BYTE = 8'h3F;   // '?'
	localparam byte_t CONT_MASK = 8'hC0;
	localparam byte_t CONT_CODE = 8'h80;
	localparam byte_t LEAD2_MASK = 8'hE0;
	localparam byte_t LEAD2_CODE = 8'hC0;
	localparam byte_t LEAD3_MASK = 8'hF0;
	localparam byte_t LEAD3_CODE = 8'hE0;
	localparam byte_t LEAD4_MASK = 8'hF8;
	localparam byte_t LEAD4_CODE = 8'hF0;

	// Sequence length announced by a lead byte, 0 when not a valid lead
	function automatic logic [2:0] lead_len(input byte_t b);
		logic [2:0] len;
		len = 3'd0;
		if ((b & LEAD2_MASK) == LEAD2_CODE) begin
			len = 3'd2;
		end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
			len = 3'd3;
		end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
			len = 3'd4;
		end
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_sanitizer.sv =====
// UTF-8 sanitizer top level: decode, sequence hold registers and result buffer.
// Depends on utf8s_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial UTF-8 clean-up. Each input transfer is decoded combinationally
// against the held sequence state and releases 0 to 4 bytes into a small
// result buffer that drains one byte per cycle on the output channel while
// out_ready is high. ASCII and complete sequences stream at one byte per cycle
// while out_ready is high; a transfer that releases n bytes holds the output
// until all n have left, and the next input is taken in the cycle the last of
// them leaves (in_ready follows out_ready combinationally in that case). Bytes
// that are only held produce no output. run_last marks the final byte released
// by a transfer; stream_last marks it as well when that transfer carried in_end.
module utf8_sanitizer (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire utf8s_pkg::byte_t in_byte,
	input  wire                   in_end,
	output logic                  out_valid,
	input  wire                   out_ready,
	output utf8s_pkg::byte_t      out_byte,
	output logic                  run_last,
	output logic                  stream_last
);
	import utf8s_pkg::*;

	// Sequence state
	byte_t       lead_q;
	byte_t       cont_q [2];
	logic [2:0]  exp_len_q;
	logic [1:0]  seen_q;

	// Result buffer
	byte_t          buf_q [MaxResults];
	logic [CntW-1:0] rem_q;
	logic           end_q;

	logic in_xfer, out_xfer;

	// Decode results
	byte_t           nb [MaxResults];
	logic [CntW-1:0] n_res;
	logic [2:0]      exp_len_d;
	logic [1:0]      seen_d;
	byte_t           lead_d;
	logic            cont_we;
	logic [2:0]      len_b;
	logic            is_cont, pending, complete, fresh;
	logic [1:0]      app_idx;

	assign out_valid   = (rem_q != '0);
	assign in_ready    = (rem_q == '0) || ((rem_q == CntW'(1)) && out_ready);
	assign in_xfer     = in_valid && in_ready;
	assign out_xfer    = out_valid && out_ready;
	assign out_byte    = buf_q[0];
	assign run_last    = (rem_q == CntW'(1));
	assign stream_last = (rem_q == CntW'(1)) && end_q;

	assign is_cont  = ((in_byte & CONT_MASK) == CONT_CODE);
	assign pending  = (exp_len_q != 3'd0);
	assign complete = (({1'b0, seen_q} + 3'd2) >= exp_len_q);
	assign len_b    = lead_len(in_byte);

	// Per-byte decode against the pending sequence
	always_comb begin
		for (int i = 0; i < MaxResults; i++) begin
			nb[i] = REPL_BYTE;
		end
		n_res     = '0;
		exp_len_d = exp_len_q;
		seen_d    = seen_q;
		lead_d    = lead_q;
		cont_we   = 1'b0;
		fresh     = 1'b1;
		app_idx   = 2'd0;

		if (pending) begin
			if (is_cont) begin
				fresh = 1'b0;
				if (complete) begin
					// release lead, held continuations and this byte
					nb[0] = lead_q;
					nb[1] = (seen_q >= 2'd1) ? cont_q[0] : in_byte;
					nb[2] = (seen_q == 2'd2) ? cont_q[1] : in_byte;
					nb[3] = in_byte;
					n_res = CntW'(seen_q) + CntW'(2);
					exp_len_d = 3'd0;
					seen_d    = 2'd0;
				end else begin
					cont_we = 1'b1;
					seen_d  = seen_q + 2'd1;
					if (in_end) begin
						// truncated: lead and every continuation become '?'
						n_res     = CntW'(seen_q) + CntW'(2);
						exp_len_d = 3'd0;
						seen_d    = 2'd0;
					end
				end
			end else begin
				// broken sequence, then handle the byte afresh
				n_res     = CntW'(seen_q) + CntW'(1);
				app_idx   = seen_q + 2'd1;
				exp_len_d = 3'd0;
				seen_d    = 2'd0;
			end
		end

		if (fresh) begin
			if (!in_byte[7]) begin
				nb[app_idx] = in_byte;
				n_res       = n_res + CntW'(1);
			end else if ((len_b == 3'd0) || in_end) begin
				n_res = n_res + CntW'(1);
			end else begin
				lead_d    = in_byte;
				exp_len_d = len_b;
				seen_d    = 2'd0;
			end
		end
	end

	// Sequence state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q    <= '0;
			exp_len_q <= '0;
			seen_q    <= '0;
		end else if (in_xfer) begin
			lead_q    <= lead_d;
			exp_len_q <= exp_len_d;
			seen_q    <= seen_d;
		end
	end

	// Held continuation bytes, no reset
	always_ff @(posedge clk) begin
		if (in_xfer && cont_we) begin
			cont_q[seen_q[0]] <= in_byte;
		end
	end

	// Result count and stream-end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			end_q <= 1'b0;
		end else if (in_xfer) begin
			rem_q <= n_res;
			end_q <= in_end;
		end else if (out_xfer) begin
			rem_q <= rem_q - CntW'(1);
		end
	end

	// Result bytes: load on input transfer, shift on output transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int i = 0; i < MaxResults; i++) begin
				buf_q[i] <= nb[i];
			end
		end else if (out_xfer) begin
			for (int i = 0; i < MaxResults - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for utf8_sanitizer: random and directed byte strings,
// predicted '?' replacement, valid/ready pressure on both channels.
// Depends on utf8s_pkg and utf8_sanitizer.
`timescale 1ns / 1ps

module testbench;
	import utf8s_pkg::*;

	localparam int RandomItems = 420;
	localparam int CycleLimit  = 200000;
	localparam int IdlePct     = 28;
	localparam int HoldStart   = 120;   // receiver hold-off begins here
	localparam int HoldLen     = 100;
	localparam int CalmFrom    = 350;   // window with no idling on either side
	localparam int CalmTo      = 550;
	localparam int TailCycles  = 20;

	typedef struct {
		byte_t b;
		logic  e;
		logic  drain;   // marker: hold the sender until all results are in
	} raw_item_t;

	typedef struct {
		byte_t b;
		logic  run_last;
		logic  stream_last;
	} clean_item_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	byte_t in_byte;
	logic  in_end;
	logic  out_valid;
	logic  out_ready;
	byte_t out_byte;
	logic  run_last;
	logic  stream_last;

	raw_item_t   raw_q[$];
	clean_item_t clean_q[$];
	int          errors = 0;
	int          n_items = 0;
	int          cyc = 0;
	logic        results_waiting;
	logic        calm;
	int          hold_left;

	// Predictor state: pending sequence
	byte_t       held_lead = 8'h00;
	byte_t       held_cont [2];
	int          seq_len = 0;
	int          cont_cnt = 0;

	utf8_sanitizer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_end     (in_end),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.stream_last(stream_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	assign calm = (cyc >= CalmFrom) && (cyc < CalmTo);

	// Sequence length from a lead byte, 0 for ASCII, continuation or bad lead
	function automatic int seq_len_of(input byte_t b);
		casez (b)
			8'b110?????: return 2;
			8'b1110????: return 3;
			8'b11110???: return 4;
			default:     return 0;
		endcase
	endfunction

	// Predict the bytes released by one accepted input transfer
	task automatic sanitize_byte(input byte_t b, input logic e);
		byte_t       rel [4];
		int          n;
		bit          fresh;
		int          seen;
		int          len;
		clean_item_t c;
		n = 0;
		fresh = 1'b1;
		if (seq_len != 0) begin
			seen = (cont_cnt > 2) ? 2 : cont_cnt;
			if ((b & CONT_MASK) == CONT_CODE) begin
				fresh = 1'b0;
				if (seen + 2 >= seq_len) begin
					// sequence complete: release as received
					rel[n] = held_lead;
					n++;
					for (int k = 0; k < seen; k++) begin
						rel[n] = held_cont[k];
						n++;
					end
					rel[n] = b;
					n++;
					seq_len = 0;
					cont_cnt = 0;
				end else begin
					held_cont[seen] = b;
					cont_cnt = seen + 1;
					// string ends mid-sequence: lead and all continuations become '?'
					if (e) begin
						for (int k = 0; k < seen + 2; k++) begin
							rel[n] = REPL_BYTE;
							n++;
						end
						seq_len = 0;
						cont_cnt = 0;
					end
				end
			end else begin
				// broken sequence: flush as '?', then treat byte afresh
				for (int k = 0; k < seen + 1; k++) begin
					rel[n] = REPL_BYTE;
					n++;
				end
				seq_len = 0;
				cont_cnt = 0;
			end
		end
		if (fresh) begin
			if (b < 8'h80) begin
				rel[n] = b;
				n++;
			end else begin
				len = seq_len_of(b);
				if (len == 0 || e) begin
					rel[n] = REPL_BYTE;
					n++;
				end else begin
					held_lead = b;
					seq_len = len;
					cont_cnt = 0;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			c.b = rel[k];
			c.run_last = (k == n - 1);
			c.stream_last = e && (k == n - 1);
			clean_q = {clean_q, c};
		end
	endtask

	task automatic add_byte(input byte_t b, input logic e);
		raw_item_t r;
		r.b = b;
		r.e = e;
		r.drain = 1'b0;
		raw_q = {raw_q, r};
		n_items++;
	endtask

	task automatic add_drain();
		raw_item_t r;
		r.b = 8'h00;
		r.e = 1'b0;
		r.drain = 1'b1;
		raw_q = {raw_q, r};
	endtask

	function automatic byte_t make_lead(input int len);
		case (len)
			2:       return {3'b110, 5'($urandom_range(31))};
			3:       return {4'b1110, 4'($urandom_range(15))};
			default: return {5'b11110, 3'($urandom_range(7))};
		endcase
	endfunction

	function automatic byte_t make_cont();
		return {2'b10, 6'($urandom_range(63))};
	endfunction

	function automatic logic rare_end();
		return ($urandom_range(19) == 0);
	endfunction

	task automatic add_random_items();
		int    pick;
		int    len;
		int    ncont;
		logic  e;
		while (n_items < RandomItems) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				add_byte(8'($urandom_range(127)), rare_end());
			end else if (pick < 75) begin
				// well-formed sequence, random payload
				len = $urandom_range(4, 2);
				e = rare_end();
				add_byte(make_lead(len), 1'b0);
				for (int k = 1; k < len; k++)
					add_byte(make_cont(), e && (k == len - 1));
			end else if (pick < 87) begin
				// short sequence: broken by the next byte or ended early
				len = $urandom_range(4, 3);
				ncont = $urandom_range(len - 2, 1);
				e = ($urandom_range(2) == 0);
				add_byte(make_lead(len), 1'b0);
				for (int k = 1; k <= ncont; k++)
					add_byte(make_cont(), e && (k == ncont));
			end else begin
				add_byte(8'($urandom_range(255)), rare_end());
			end
			if (n_items >= RandomItems / 2 && n_items < RandomItems / 2 + 4 &&
					!raw_q[$].drain) begin
				add_drain();
				n_items += 4;
			end
		end
	endtask

	// Stimulus, reset and end of run
	initial begin
		arst_n = 1'b0;
		// ASCII extremes
		add_byte(8'h00, 1'b0);
		add_byte(8'h7F, 1'b0);
		// two, three and four byte sequences
		add_byte(8'hC3, 1'b0);
		add_byte(8'hA9, 1'b0);
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'hAC, 1'b0);
		add_byte(8'hF0, 1'b0);
		add_byte(8'h9F, 1'b0);
		add_byte(8'h98, 1'b0);
		add_byte(8'h80, 1'b1);
		// stray continuations and invalid leads
		add_byte(8'h80, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hF8, 1'b0);
		add_byte(8'hFF, 1'b0);
		// sequence broken by ASCII
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b0);
		add_byte(8'h41, 1'b0);
		// string ends inside a sequence
		add_byte(8'hF7, 1'b0);
		add_byte(8'hBF, 1'b1);
		// lead byte with end of string
		add_byte(8'hDF, 1'b1);
		add_byte(8'h41, 1'b1);
		add_drain();
		n_items = 0;
		add_random_items();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (raw_q.size() != 0 || in_valid || clean_q.size() != 0);
		repeat (TailCycles) @(negedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Cycle count and timeout
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Input driver
	always @(posedge clk or negedge arst_n) begin : drv
		logic go;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
			in_end   <= 1'b0;
		end else if (!in_valid || in_ready) begin
			go = calm || ($urandom_range(99) >= IdlePct);
			if (raw_q.size() != 0 && raw_q[0].drain) begin
				in_valid <= 1'b0;
				if (!in_valid && !results_waiting)
					raw_q.delete(0);
			end else if (raw_q.size() != 0 && go) begin
				in_valid <= 1'b1;
				in_byte  <= raw_q[0].b;
				in_end   <= raw_q[0].e;
				raw_q.delete(0);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else if (cyc == HoldStart) begin
			out_ready <= 1'b0;
			hold_left <= HoldLen;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IdlePct);
		end
	end

	// Monitor: predict on input transfers, check output transfers
	always @(posedge clk or negedge arst_n) begin : mon
		clean_item_t c;
		if (!arst_n) begin
			results_waiting <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				sanitize_byte(in_byte, in_end);
			if (out_valid && out_ready) begin
				if (clean_q.size() == 0) begin
					$error("unexpected output byte %02h", out_byte);
					errors++;
				end else begin
					c = clean_q.pop_front();
					if (out_byte !== c.b) begin
						$error("out_byte: expected %02h, got %02h", c.b, out_byte);
						errors++;
					end
					if (run_last !== c.run_last) begin
						$error("run_last: expected %0b, got %0b", c.run_last, run_last);
						errors++;
					end
					if (stream_last !== c.stream_last) begin
						$error("stream_last: expected %0b, got %0b",
							c.stream_last, stream_last);
						errors++;
					end
				end
			end
			results_waiting <= (clean_q.size() != 0);
		end
	end

endmodule
